FILE: hw/rtl/mspid_pkg.sv
// Shared types, constants and rounding helper for the motor speed PID block.
// No dependencies; used by mspid_ctrl, mspid_datapath and motor_speed_pid_core.
`default_nettype none

package mspid_pkg;

  localparam int COUNT_BITS_DEF = 16;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // Q.4 limits (LOW_REF_RPM is in whole rpm)
  localparam int DRIVE_MAX   = 4080;
  localparam int RPM_MAX     = 524287;
  localparam int RPM_MIN     = -524288;
  localparam int LOW_REF_RPM = 120;
  localparam int BAND_LOW    = 80;
  localparam int BAND_HIGH   = 40;

  localparam int PROD_W = 39;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PROP_GAIN   = 3'd0,
    CFG_INTEG_GAIN  = 3'd1,
    CFG_DERIV_GAIN  = 3'd2,
    CFG_INTEG_LIMIT = 3'd3,
    CFG_RPM_SCALE   = 3'd4,
    CFG_CLOCKWISE   = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MUL_RPM,
    MUL_PROP,
    MUL_INTEG,
    MUL_DERIV
  } mul_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RPM,
    ST_ERR,
    ST_PROP,
    ST_INTEG,
    ST_DERIV,
    ST_SUM,
    ST_DRIVE,
    ST_DONE
  } state_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    logic     load_in;
    logic     load_err;
    logic     decide;
    logic     acc_p;
    logic     integ_upd;
    logic     acc_sum;
    logic     drive_upd;
    logic     finish;
  } dp_cmd_t;

  typedef struct packed {
    logic stop;
    logic in_band;
  } dp_stat_t;

  // Arithmetic right shift, round to nearest, ties away from zero.
  function automatic logic signed [PROD_W-1:0] rnd_shr(input logic signed [PROD_W-1:0] v,
                                                       input int unsigned sh);
    logic signed [PROD_W-1:0] bias;
    bias = (PROD_W'(1) <<< (sh - 1)) - (v[PROD_W-1] ? PROD_W'(1) : PROD_W'(0));
    return (v + bias) >>> sh;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mspid_ctrl.sv
// Sequencer for the motor speed PID: walks one request through the shared multiplier.
// Depends on mspid_pkg; drives mspid_datapath through dp_cmd_t.
`default_nettype none

module mspid_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire mspid_pkg::dp_stat_t stat_i,
  output mspid_pkg::dp_cmd_t       cmd_o
);

  mspid_pkg::state_e state_q, state_d;
  logic              out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mspid_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.mul_sel = mspid_pkg::MUL_RPM;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      mspid_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          state_d = mspid_pkg::ST_RPM;
        end
      end
      mspid_pkg::ST_RPM: begin
        cmd_o.mul_sel = mspid_pkg::MUL_RPM;
        state_d       = mspid_pkg::ST_ERR;
      end
      mspid_pkg::ST_ERR: begin
        cmd_o.load_err = 1'b1;
        state_d        = mspid_pkg::ST_PROP;
      end
      mspid_pkg::ST_PROP: begin
        cmd_o.mul_sel = mspid_pkg::MUL_PROP;
        cmd_o.decide  = 1'b1;
        // stop and dead band skip the PID update
        if (stat_i.stop || stat_i.in_band) begin
          state_d = mspid_pkg::ST_DONE;
        end else begin
          state_d = mspid_pkg::ST_INTEG;
        end
      end
      mspid_pkg::ST_INTEG: begin
        cmd_o.mul_sel = mspid_pkg::MUL_INTEG;
        cmd_o.acc_p   = 1'b1;
        state_d       = mspid_pkg::ST_DERIV;
      end
      mspid_pkg::ST_DERIV: begin
        cmd_o.mul_sel   = mspid_pkg::MUL_DERIV;
        cmd_o.integ_upd = 1'b1;
        state_d         = mspid_pkg::ST_SUM;
      end
      mspid_pkg::ST_SUM: begin
        cmd_o.acc_sum = 1'b1;
        state_d       = mspid_pkg::ST_DRIVE;
      end
      mspid_pkg::ST_DRIVE: begin
        cmd_o.drive_upd = 1'b1;
        state_d         = mspid_pkg::ST_DONE;
      end
      mspid_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = mspid_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mspid_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: hw/rtl/mspid_datapath.sv
// Datapath for the motor speed PID: config registers, one shared 17x22 multiplier,
// rounding, clamps, controller state and output payload. Depends on mspid_pkg.
`default_nettype none

module mspid_datapath #(
  parameter int COUNT_BITS = mspid_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [mspid_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  wire logic [mspid_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic signed [15:0]                  pulse_count_i,
  input  wire logic signed [15:0]                  speed_ref_i,
  input  wire mspid_pkg::dp_cmd_t                  cmd_i,
  output mspid_pkg::dp_stat_t                      stat_o,
  output logic [7:0]                               pwm_duty_o,
  output logic                                     pwm_update_o,
  output logic signed [19:0]                       measured_rpm_o,
  output logic signed [12:0]                       drive_level_o
);

  localparam int PW = mspid_pkg::PROD_W;

  // configuration
  logic [15:0] prop_gain_q, integ_gain_q, deriv_gain_q, integ_limit_q, rpm_scale_q;
  logic        clockwise_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q   <= 16'd256;
      integ_gain_q  <= 16'd0;
      deriv_gain_q  <= 16'd0;
      integ_limit_q <= 16'd4080;
      rpm_scale_q   <= 16'd256;
      clockwise_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (mspid_pkg::cfg_idx_e'(cfg_addr_i))
        mspid_pkg::CFG_PROP_GAIN:   prop_gain_q   <= cfg_data_i;
        mspid_pkg::CFG_INTEG_GAIN:  integ_gain_q  <= cfg_data_i;
        mspid_pkg::CFG_DERIV_GAIN:  deriv_gain_q  <= cfg_data_i;
        mspid_pkg::CFG_INTEG_LIMIT: integ_limit_q <= cfg_data_i;
        mspid_pkg::CFG_RPM_SCALE:   rpm_scale_q   <= cfg_data_i;
        mspid_pkg::CFG_CLOCKWISE:   clockwise_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // controller state
  logic signed [15:0] last_cnt_q;
  logic signed [20:0] last_err_q;
  logic signed [16:0] integ_q, integ_d;
  logic signed [12:0] drive_q, drive_d;

  // per-request working registers
  logic signed [15:0] cnt_q, sref_q;
  logic signed [19:0] rpm_q, rpm_d;
  logic signed [20:0] err_q, err_d;
  logic signed [PW-1:0] prod_q, prod_d;
  logic signed [31:0] acc_q;
  logic               upd_q;

  // output payload
  logic [7:0]         duty_out_q;
  logic               upd_out_q;
  logic signed [19:0] rpm_out_q;
  logic signed [12:0] drive_out_q;

  // counter delta with wrap at COUNT_BITS
  logic signed [16:0] diff17, delta;
  assign diff17 = {cnt_q[15], cnt_q} - {last_cnt_q[15], last_cnt_q};

  if (COUNT_BITS >= 17) begin : g_wide_cnt
    assign delta = diff17;
  end else begin : g_narrow_cnt
    assign delta = {{(17-COUNT_BITS){diff17[COUNT_BITS-1]}}, diff17[COUNT_BITS-1:0]};
  end

  // shared multiplier
  logic signed [16:0] mul_a;
  logic signed [21:0] mul_b;

  always_comb begin
    case (cmd_i.mul_sel)
      mspid_pkg::MUL_RPM: begin
        mul_a = {1'b0, rpm_scale_q};
        mul_b = {{5{delta[16]}}, delta};
      end
      mspid_pkg::MUL_PROP: begin
        mul_a = {1'b0, prop_gain_q};
        mul_b = {err_q[20], err_q};
      end
      mspid_pkg::MUL_INTEG: begin
        mul_a = {1'b0, integ_gain_q};
        mul_b = {err_q[20], err_q};
      end
      mspid_pkg::MUL_DERIV: begin
        mul_a = {1'b0, deriv_gain_q};
        mul_b = {err_q[20], err_q} - {last_err_q[20], last_err_q};
      end
      default: begin
        mul_a = {1'b0, rpm_scale_q};
        mul_b = {{5{delta[16]}}, delta};
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // speed, reference and error
  logic signed [PW-1:0] rpm_full, prod_r8;
  logic signed [20:0]   ref_s;
  logic signed [21:0]   diff22;

  assign rpm_full = mspid_pkg::rnd_shr(prod_q, 4);
  assign prod_r8  = mspid_pkg::rnd_shr(prod_q, 8);

  always_comb begin
    if (rpm_full > PW'(mspid_pkg::RPM_MAX)) begin
      rpm_d = 20'(mspid_pkg::RPM_MAX);
    end else if (rpm_full < PW'(mspid_pkg::RPM_MIN)) begin
      rpm_d = 20'(mspid_pkg::RPM_MIN);
    end else begin
      rpm_d = rpm_full[19:0];
    end
    ref_s  = clockwise_q ? {sref_q[15], sref_q, 4'b0000} : -{sref_q[15], sref_q, 4'b0000};
    diff22 = {ref_s[20], ref_s} - {{2{rpm_d[19]}}, rpm_d};
    if (diff22[21] != diff22[20]) begin
      err_d = diff22[21] ? {1'b1, 20'd0} : {1'b0, {20{1'b1}}};
    end else begin
      err_d = diff22[20:0];
    end
  end

  // branch decision
  logic [21:0] err_mag;
  logic [21:0] band;
  logic        low_ref;

  assign err_mag = err_q[20] ? -{err_q[20], err_q} : {err_q[20], err_q};
  assign low_ref = (sref_q < 16'(mspid_pkg::LOW_REF_RPM)) &&
                   (sref_q > -16'(mspid_pkg::LOW_REF_RPM));
  assign band    = low_ref ? 22'(mspid_pkg::BAND_LOW) : 22'(mspid_pkg::BAND_HIGH);

  assign stat_o.stop    = (sref_q == 16'sd0);
  assign stat_o.in_band = (err_mag <= band);

  // integrator clamp
  logic signed [PW-1:0] integ_sum, lim;
  assign integ_sum = {{(PW-17){integ_q[16]}}, integ_q} + prod_r8;
  assign lim       = {{(PW-16){1'b0}}, integ_limit_q};

  always_comb begin
    if (integ_sum > lim) begin
      integ_d = lim[16:0];
    end else if (integ_sum < -lim) begin
      integ_d = 17'(-lim);
    end else begin
      integ_d = integ_sum[16:0];
    end
  end

  // drive saturation
  always_comb begin
    if (acc_q > 32'(mspid_pkg::DRIVE_MAX)) begin
      drive_d = 13'(mspid_pkg::DRIVE_MAX);
    end else if (acc_q < -32'(mspid_pkg::DRIVE_MAX)) begin
      drive_d = -13'(mspid_pkg::DRIVE_MAX);
    end else begin
      drive_d = acc_q[12:0];
    end
  end

  logic [12:0] drive_mag, duty_rnd;
  assign drive_mag = drive_q[12] ? -drive_q : drive_q;
  assign duty_rnd  = drive_mag + 13'd8;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cnt_q <= '0;
      last_err_q <= '0;
      integ_q    <= '0;
      drive_q    <= '0;
    end else begin
      if (cmd_i.decide && stat_o.stop) begin
        integ_q <= '0;
        drive_q <= '0;
      end
      if (cmd_i.integ_upd) begin
        integ_q <= integ_d;
      end
      if (cmd_i.drive_upd) begin
        drive_q <= drive_d;
      end
      if (cmd_i.finish) begin
        last_cnt_q <= cnt_q;
        last_err_q <= err_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.load_in) begin
      cnt_q  <= pulse_count_i;
      sref_q <= speed_ref_i;
    end
    if (cmd_i.load_err) begin
      rpm_q <= rpm_d;
      err_q <= err_d;
    end
    if (cmd_i.decide) begin
      upd_q <= stat_o.stop || !stat_o.in_band;
    end
    if (cmd_i.acc_p) begin
      acc_q <= {{19{drive_q[12]}}, drive_q} + prod_r8[31:0];
    end
    if (cmd_i.acc_sum) begin
      acc_q <= acc_q + {{15{integ_q[16]}}, integ_q} + prod_r8[31:0];
    end
    if (cmd_i.finish) begin
      duty_out_q  <= upd_q ? duty_rnd[11:4] : 8'd0;
      upd_out_q   <= upd_q;
      rpm_out_q   <= rpm_q;
      drive_out_q <= drive_q;
    end
  end

  assign pwm_duty_o     = duty_out_q;
  assign pwm_update_o   = upd_out_q;
  assign measured_rpm_o = rpm_out_q;
  assign drive_level_o  = drive_out_q;

endmodule

`default_nettype wire

FILE: hw/rtl/motor_speed_pid_core.sv
// Motor speed PID controller, top level: sequencer plus datapath.
// Depends on mspid_pkg, mspid_ctrl and mspid_datapath.
//
// One request per control period: pulse_count_i (encoder counter) and speed_ref_i
// (whole rpm) on a valid/ready input channel. Each request yields exactly one result
// on the output channel: pwm_duty_o, pwm_update_o, measured_rpm_o (Q.4) and
// drive_level_o (Q.4).
// A request runs through one shared 17x22 multiplier, one product per cycle:
// speed, then P, I and D terms. A zero reference or an error inside the dead band
// skips the I, D, sum and drive steps and goes straight to the result step.
// A new request is taken only after the result of the last one is registered;
// the block does not accept one while it is still working on a request.
// The result sits in an output register; a stalled receiver does not block the
// next request from being accepted and computed, but its result waits in the last
// step until the output register is taken.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_addr_i (0 prop gain,
// 1 integral gain, 2 derivative gain, 3 integrator limit, 4 rpm scale, 5 clockwise).
// The user writes only while the block is idle (the block does not enforce it). Reset
// restores the default gains and clears the last count, last error, integrator and drive.
`default_nettype none

module motor_speed_pid_core #(
  parameter int COUNT_BITS = mspid_pkg::COUNT_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [mspid_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [mspid_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic signed [15:0]               pulse_count_i,
  input  wire logic signed [15:0]               speed_ref_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [7:0]                            pwm_duty_o,
  output logic                                  pwm_update_o,
  output logic signed [19:0]                    measured_rpm_o,
  output logic signed [12:0]                    drive_level_o
);

  mspid_pkg::dp_cmd_t  cmd;
  mspid_pkg::dp_stat_t stat;

  mspid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mspid_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .pulse_count_i  (pulse_count_i),
    .speed_ref_i    (speed_ref_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .pwm_duty_o     (pwm_duty_o),
    .pwm_update_o   (pwm_update_o),
    .measured_rpm_o (measured_rpm_o),
    .drive_level_o  (drive_level_o)
  );

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for motor_speed_pid_core: directed and random control periods.
// An in-place PID predictor queues each expected result; every output is checked against it.
// Depends on mspid_pkg and the motor_speed_pid_core RTL.
module testbench;

  localparam int     CYCLE_LIMIT       = 500000;
  localparam int     SETTLE_CYCLES     = 12;
  localparam int     ITEMS_PER_SETTING = 210;
  localparam int     MAX_REPORTS       = 10;
  localparam longint ERR_MAX_Q4        = 1048575;
  localparam longint ERR_MIN_Q4        = -1048576;
  localparam longint LOW_REF_Q4        = mspid_pkg::LOW_REF_RPM * 16;

  typedef enum int {
    CFG_STYLE_TYPICAL,
    CFG_STYLE_ANY,
    CFG_STYLE_ALL_MAX,
    CFG_STYLE_ALL_ZERO
  } cfg_style_e;

  typedef struct packed {
    logic [7:0]  duty;
    logic        update;
    logic [19:0] rpm;
    logic [12:0] drive;
  } pid_result_t;

  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             cfg_we_i      = 1'b0;
  logic [mspid_pkg::CFG_ADDR_W-1:0] cfg_addr_i    = mspid_pkg::CFG_PROP_GAIN;
  logic [mspid_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                             in_valid_i    = 1'b0;
  logic                             in_ready_o;
  logic signed [15:0]               pulse_count_i = '0;
  logic signed [15:0]               speed_ref_i   = '0;
  logic                             out_valid_o;
  logic                             out_ready_i   = 1'b0;
  logic [7:0]                       pwm_duty_o;
  logic                             pwm_update_o;
  logic signed [19:0]               measured_rpm_o;
  logic signed [12:0]               drive_level_o;

  // predictor copy of the registers and the loop state
  logic [15:0] gain_p      = 16'd256;
  logic [15:0] gain_i      = 16'd0;
  logic [15:0] gain_d      = 16'd0;
  logic [15:0] integ_lim   = 16'd4080;
  logic [15:0] speed_scale = 16'd256;
  logic        cw_dir      = 1'b1;
  longint      last_cnt_q  = 0;
  longint      last_err_q  = 0;
  longint      integ_q     = 0;
  longint      drive_q     = 0;

  pid_result_t expected_results[$];
  logic [15:0] sent_count     = '0;
  int          send_idle_pct  = 20;
  int          recv_stall_pct = 83;
  int          mismatch_count = 0;
  int          cycle_count    = 0;

  motor_speed_pid_core uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  function automatic longint round_shr(input longint v, input int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << (sh - 1))) >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint abs_val(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // One control period: speed from the count delta, then stop, dead band or PID update.
  function automatic pid_result_t predict_period(input logic [15:0] count,
                                                 input logic [15:0] sref);
    pid_result_t r;
    logic [15:0] diff;
    longint      delta, rpm, ref_q4, err, band, lim, p_term, i_term, d_term;
    diff   = count - last_cnt_q[15:0];
    delta  = $signed(diff);
    rpm    = sat(round_shr(delta * longint'(speed_scale), 4),
                 mspid_pkg::RPM_MIN, mspid_pkg::RPM_MAX);
    ref_q4 = $signed(sref);
    ref_q4 = ref_q4 * 16;
    if (!cw_dir) ref_q4 = -ref_q4;
    err      = sat(ref_q4 - rpm, ERR_MIN_Q4, ERR_MAX_Q4);
    r.duty   = '0;
    r.update = 1'b0;
    if (ref_q4 == 0) begin
      drive_q  = 0;
      integ_q  = 0;
      r.update = 1'b1;
    end else begin
      band = (abs_val(ref_q4) < LOW_REF_Q4) ? mspid_pkg::BAND_LOW : mspid_pkg::BAND_HIGH;
      if (abs_val(err) > band) begin
        lim      = longint'(integ_lim);
        p_term   = round_shr(longint'(gain_p) * err, 8);
        i_term   = integ_q + round_shr(longint'(gain_i) * err, 8);
        d_term   = round_shr(longint'(gain_d) * (err - last_err_q), 8);
        integ_q  = sat(i_term, -lim, lim);
        drive_q  = sat(drive_q + p_term + integ_q + d_term,
                       -mspid_pkg::DRIVE_MAX, mspid_pkg::DRIVE_MAX);
        r.duty   = 8'((abs_val(drive_q) + 8) >> 4);
        r.update = 1'b1;
      end
    end
    last_err_q = err;
    last_cnt_q = longint'(count);
    r.rpm      = rpm[19:0];
    r.drive    = drive_q[12:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    pid_result_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {pwm_duty_o, pwm_update_o, measured_rpm_o, drive_level_o};
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: duty %0d update %0d rpm %0d drive %0d",
                   got.duty, got.update, $signed(got.rpm), $signed(got.drive));
      end else begin
        want = expected_results.pop_front();
        if (got.duty !== want.duty || got.update !== want.update ||
            got.rpm !== want.rpm || got.drive !== want.drive) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch (exp/got): duty %0d/%0d update %0d/%0d rpm %0d/%0d drive %0d/%0d",
                     want.duty, got.duty, want.update, got.update,
                     $signed(want.rpm), $signed(got.rpm),
                     $signed(want.drive), $signed(got.drive));
        end
      end
    end
  end

  // Valid is only lowered when the sender idles, so it never drops between back-to-back requests.
  task automatic send_request(input logic [15:0] count, input logic [15:0] sref);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pulse_count_i <= count;
    speed_ref_i   <= sref;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_results.push_back(predict_period(count, sref));
    sent_count = count;
  endtask

  task automatic send_delta(input int delta, input int sref);
    send_request(16'(sent_count + delta), 16'(sref));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input mspid_pkg::cfg_idx_e idx,
                           input logic [mspid_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [15:0] kp, input logic [15:0] ki,
                               input logic [15:0] kd, input logic [15:0] ilim,
                               input logic [15:0] scale, input logic cw);
    write_reg(mspid_pkg::CFG_PROP_GAIN, kp);
    write_reg(mspid_pkg::CFG_INTEG_GAIN, ki);
    write_reg(mspid_pkg::CFG_DERIV_GAIN, kd);
    write_reg(mspid_pkg::CFG_INTEG_LIMIT, ilim);
    write_reg(mspid_pkg::CFG_RPM_SCALE, scale);
    write_reg(mspid_pkg::CFG_CLOCKWISE, {15'b0, cw});
    cfg_we_i    <= 1'b0;
    gain_p      = kp;
    gain_i      = ki;
    gain_d      = kd;
    integ_lim   = ilim;
    speed_scale = scale;
    cw_dir      = cw;
  endtask

  // Mostly periods whose count tracks the reference, so the dead band and small errors
  // are reached; the rest is stop requests and unrelated counts and references.
  task automatic send_random_period();
    int                 mode, sref_v, delta_v;
    logic signed [15:0] rnd16;
    mode = $urandom_range(99);
    if (mode < 8) begin
      sref_v = 0;
    end else if (mode < 70) begin
      sref_v = int'($urandom_range(6000)) - 3000;
    end else begin
      rnd16  = 16'($urandom);
      sref_v = rnd16;
    end
    if (mode >= 80 || speed_scale == 0) begin
      rnd16   = 16'($urandom);
      delta_v = rnd16;
    end else begin
      delta_v = ((cw_dir ? sref_v : -sref_v) * 256) / int'(speed_scale);
      delta_v = delta_v + int'($urandom_range(8)) - 4;
      delta_v = int'(sat(delta_v, -32768, 32767));
    end
    send_delta(delta_v, sref_v);
  endtask

  task automatic run_random_setting(input cfg_style_e style);
    drain_results();
    case (style)
      CFG_STYLE_TYPICAL: begin
        load_settings(16'($urandom_range(32, 1024)), 16'($urandom_range(256)),
                      16'($urandom_range(512)), 16'($urandom_range(4080)),
                      16'($urandom_range(16, 1024)), 1'($urandom_range(1)));
      end
      CFG_STYLE_ANY: begin
        load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 1'($urandom));
      end
      CFG_STYLE_ALL_MAX: begin
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      end
      default: begin
        load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      end
    endcase
    repeat (ITEMS_PER_SETTING) send_random_period();
  endtask

  // Reset gains: rpm_scale 1.0 makes one pulse per period equal one rpm.
  task automatic test_directed_bands();
    send_delta(0, 0);              // stop
    send_delta(100, 100);          // zero error
    send_delta(95, 100);           // error right at the low band edge
    send_delta(94, 100);           // just outside: PID update
    send_delta(-30, -119);
    send_delta(-119, -119);
    send_delta(120, 120);          // 120 rpm switches to the narrow band
    send_delta(118, 120);
    send_delta(117, 120);
    send_request(16'h7FFF, 16'sd50);
    send_request(16'h8000, 16'sd50); // counter wraps forward
    send_request(16'h7FFF, 16'sd50); // and back
    send_delta(0, 32767);
    send_delta(0, -32768);
    send_delta(0, 0);
  endtask

  task automatic test_directed_limits();
    drain_results();
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
    send_delta(-32768, -32768);    // speed and error both saturate, drive at top
    send_delta(32767, 32767);      // speed saturates, drive at the bottom
    send_delta(1, 1);
    drain_results();
    load_settings(16'd256, 16'h0800, 16'h0100, 16'd300, 16'd256, 1'b1);
    send_delta(0, 500);            // integrator hits +limit
    send_delta(0, 500);
    send_delta(0, -500);           // and -limit
    send_delta(0, -500);
    send_delta(-480, -500);
  endtask

  task automatic test_random_stalled_receiver();
    send_idle_pct  = 20;
    recv_stall_pct = 83;
    run_random_setting(CFG_STYLE_TYPICAL);
    run_random_setting(CFG_STYLE_ALL_MAX);
    run_random_setting(CFG_STYLE_TYPICAL);
  endtask

  task automatic test_random_stalled_sender();
    send_idle_pct  = 83;
    recv_stall_pct = 20;
    run_random_setting(CFG_STYLE_ANY);
    run_random_setting(CFG_STYLE_ALL_ZERO);
    run_random_setting(CFG_STYLE_TYPICAL);
  endtask

  task automatic test_random_full_rate();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_setting(CFG_STYLE_TYPICAL);
    run_random_setting(CFG_STYLE_ANY);
    run_random_setting(CFG_STYLE_TYPICAL);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_bands();
    test_directed_limits();
    test_random_stalled_receiver();
    test_random_stalled_sender();
    test_random_full_rate();
    drain_results();
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
